FILE: design/rlesd_pkg.sv
// ----------------------------------------------------------------------------
// rlesd_pkg
// Types and constants shared by the run-length decoder with delta runs.
// ----------------------------------------------------------------------------
`default_nettype none

package rlesd_pkg;

  // width of the reported decoded-byte count
  localparam int unsigned DCOUNT_WIDTH = 32;

  // header byte layout
  localparam int unsigned CODE_SHIFT = 6;
  localparam logic [5:0]  COUNT_MASK = 6'd63;

  // token codes from the header
  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_REPEAT  = 2'd1;
  localparam logic [1:0] KIND_DOWN    = 2'd2;
  localparam logic [1:0] KIND_UP      = 2'd3;

  // decoder sequencer states
  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_LITERAL = 2'd1,
    ST_VALUE   = 2'd2,
    ST_RUN     = 2'd3
  } rlesd_state_t;

  // control for the shared step unit
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } rlesd_step_req_t;

endpackage

`default_nettype wire

FILE: design/rle_with_sequences_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_with_sequences_decoder_unit
// Run-length decoder with literal, repeat, count-down and count-up runs.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid / in_stall, one compressed byte per request,
//                    with in_end_of_block on the final byte of a block
//   output channel : out_valid / out_stall, one decoded byte per request,
//                    with run_last, block_end and a saturating byte count
// Token handling and throughput:
//   a header byte gives no result
//   a literal byte's result appears in the cycle after it is taken
//   a run value byte is taken, then the run of N bytes (1 to 64)
//   leaves at one byte per cycle unless the receiver stalls; in_stall
//   stays high until the run ends, the step unit giving each next byte
// Reset (rst_n low, synchronous): the decoder expects a header, counts
//   are cleared and the output register is empty.
// Receiver stall: the output register holds its request; input is taken
//   only when that register is free or being emptied, and run output
//   pauses until the receiver takes the pending byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_with_sequences_decoder_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // compressed input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_compressed_byte,
  input  wire logic        in_end_of_block,
  // decoded output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_block_end,
  output logic [rlesd_pkg::DCOUNT_WIDTH-1:0] out_decoded_count
);
  import rlesd_pkg::*;

  // sequencer and token state
  rlesd_state_t           state_r, state_nxt;
  logic [1:0]             kind_r;
  logic [6:0]             rem_r;
  logic [7:0]             val_r;
  logic                   eob_r;
  logic [COUNT_WIDTH-1:0] total_r;

  // output register
  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic                   out_run_last_r;
  logic                   out_block_end_r;
  logic [DCOUNT_WIDTH-1:0] out_count_r;

  // handshake and control
  logic                   can_load;
  logic                   in_acc;
  logic                   run_fire;
  logic                   rem_one;
  logic                   load_out;
  logic [7:0]             load_byte;
  logic                   load_bend;
  logic [1:0]             hdr_code;

  // shared step unit
  rlesd_step_req_t        step_req;
  logic [7:0]             step_value;
  logic [COUNT_WIDTH-1:0] step_count;
  logic [DCOUNT_WIDTH-1:0] step_count_low;

  // handshake
  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_RUN) || !can_load;
  assign in_acc   = in_valid && !in_stall;
  assign run_fire = (state_r == ST_RUN) && can_load;
  assign rem_one  = (rem_r == 7'd1);
  assign hdr_code = in_compressed_byte[CODE_SHIFT +: 2];

  assign step_req.kind  = kind_r;
  assign step_req.value = val_r;

  rlesd_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .req       (step_req),
    .count     (total_r),
    .value_nxt (step_value),
    .count_nxt (step_count)
  );

  // low bits of the count as reported
  if (COUNT_WIDTH >= DCOUNT_WIDTH) begin : g_cnt_wide
    assign step_count_low = step_count[DCOUNT_WIDTH-1:0];
  end else begin : g_cnt_narrow
    assign step_count_low = {{(DCOUNT_WIDTH-COUNT_WIDTH){1'b0}}, step_count};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HEADER: begin
        if (in_acc && !in_end_of_block) begin
          state_nxt = (hdr_code == KIND_LITERAL) ? ST_LITERAL : ST_VALUE;
        end
      end
      ST_LITERAL: begin
        if (in_acc && (in_end_of_block || rem_one)) begin
          state_nxt = ST_HEADER;
        end
      end
      ST_VALUE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_fire && rem_one) begin
          state_nxt = ST_HEADER;
        end
      end
      default: state_nxt = ST_HEADER;
    endcase
  end

  // output load selection
  always_comb begin
    load_out  = 1'b0;
    load_byte = val_r;
    load_bend = 1'b0;
    case (state_r)
      ST_LITERAL: begin
        load_out  = in_acc;
        load_byte = in_compressed_byte;
        load_bend = in_end_of_block;
      end
      ST_RUN: begin
        load_out  = run_fire;
        load_byte = val_r;
        load_bend = rem_one && eob_r;
      end
      default: begin
        load_out  = 1'b0;
        load_byte = val_r;
        load_bend = 1'b0;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  // token state and running count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_LITERAL;
      rem_r   <= 7'd0;
      total_r <= '0;
      eob_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_HEADER: begin
          if (in_acc) begin
            if (in_end_of_block) begin
              kind_r  <= KIND_LITERAL;
              rem_r   <= 7'd0;
              total_r <= '0;
            end else begin
              kind_r <= hdr_code;
              rem_r  <= {1'b0, in_compressed_byte[5:0] & COUNT_MASK} + 7'd1;
            end
          end
        end
        ST_LITERAL: begin
          if (in_acc) begin
            if (in_end_of_block) begin
              kind_r  <= KIND_LITERAL;
              rem_r   <= 7'd0;
              total_r <= '0;
            end else begin
              rem_r   <= rem_r - 7'd1;
              total_r <= step_count;
            end
          end
        end
        ST_VALUE: begin
          if (in_acc) begin
            eob_r <= in_end_of_block;
          end
        end
        ST_RUN: begin
          if (run_fire) begin
            rem_r <= rem_r - 7'd1;
            if (rem_one && eob_r) begin
              kind_r  <= KIND_LITERAL;
              total_r <= '0;
            end else begin
              total_r <= step_count;
            end
          end
        end
        default: begin
          rem_r <= 7'd0;
        end
      endcase
    end
  end

  // run value register
  always_ff @(posedge clk) begin
    if (state_r == ST_VALUE && in_acc) begin
      val_r <= in_compressed_byte;
    end else if (run_fire) begin
      val_r <= step_value;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte_r      <= load_byte;
      out_run_last_r  <= (state_r == ST_LITERAL) || rem_one;
      out_block_end_r <= load_bend;
      out_count_r     <= step_count_low;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_run_last      = out_run_last_r;
  assign out_block_end     = out_block_end_r;
  assign out_decoded_count = out_count_r;

endmodule

`default_nettype wire

FILE: design/rlesd_step.sv
// ----------------------------------------------------------------------------
// rlesd_step
// Shared step unit: advances the run value by the token delta and bumps
// the saturating decoded-byte count, once per emitted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rlesd_step #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire rlesd_pkg::rlesd_step_req_t req,
  input  wire logic [COUNT_WIDTH-1:0]     count,
  output logic [7:0]                      value_nxt,
  output logic [COUNT_WIDTH-1:0]          count_nxt
);
  import rlesd_pkg::*;

  // next byte of the run, modulo 256
  always_comb begin
    case (req.kind)
      KIND_DOWN: value_nxt = req.value - 8'd1;
      KIND_UP:   value_nxt = req.value + 8'd1;
      default:   value_nxt = req.value;
    endcase
  end

  // saturating count
  assign count_nxt = (&count) ? count : count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

endmodule

`default_nettype wire

FILE: design/rlesd_checker.sv
// ----------------------------------------------------------------------------
// rlesd_checker
// Port-level checks on the run-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlesd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_byte,
  input wire logic        out_run_last,
  input wire logic        out_block_end,
  input wire logic [31:0] out_decoded_count
);

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_decoded_count) && $stable(out_run_last))
    else $error("stalled output request changed");

  // block end only on the last byte of a request
  a_bend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end |-> out_run_last)
    else $error("block_end without run_last");

  // count includes the byte itself and saturates, never zero
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_decoded_count != 32'd0)
    else $error("decoded count is zero on a result");

  // a run streams without gaps until its last byte
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |=> out_valid)
    else $error("gap inside a run");

  // no input taken while a run is still streaming
  a_no_in_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !(in_valid && !in_stall))
    else $error("input taken in the middle of a run");

endmodule

bind rle_with_sequences_decoder_unit rlesd_checker u_rlesd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_run_last      (out_run_last),
  .out_block_end     (out_block_end),
  .out_decoded_count (out_decoded_count)
);

`default_nettype wire

FILE: test/tb_rle_with_sequences_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rle_with_sequences_decoder_unit
// Drives compressed token streams into the run-length decoder. A built-in
// predictor models literal, repeat, count-down and count-up tokens, block
// ends and truncation. Every decoded request is checked field by field,
// with random gaps on both sides and a long output hold.
// ----------------------------------------------------------------------------
module tb_rle_with_sequences_decoder_unit;
  import rlesd_pkg::*;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [63:0] COUNT_SAT   = ((64'd1 << (COUNT_WIDTH - 1)) * 2) - 1;

  // one decoded byte as the predictor expects it
  typedef struct {
    logic [7:0]              value;
    logic                    run_last;
    logic                    block_end;
    logic [DCOUNT_WIDTH-1:0] count;
  } decoded_byte_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              in_compressed_byte = 8'd0;
  logic                    in_end_of_block = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [7:0]              out_byte;
  logic                    out_run_last;
  logic                    out_block_end;
  logic [DCOUNT_WIDTH-1:0] out_decoded_count;

  // decoder state as predicted
  rlesd_state_t  pred_phase = ST_HEADER;
  logic [1:0]    pred_kind = KIND_LITERAL;
  logic [6:0]    pred_left = 7'd0;
  logic [63:0]   pred_total = 64'd0;
  decoded_byte_t decoded_q[$];

  // bookkeeping
  int   errors = 0;
  int   bytes_sent = 0;
  int   cycle_cnt = 0;
  int   rx_wait = 0;
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  logic hold_active = 1'b0;
  decoded_byte_t want;

  rle_with_sequences_decoder_unit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_compressed_byte(in_compressed_byte),
    .in_end_of_block   (in_end_of_block),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_block_end     (out_block_end),
    .out_decoded_count (out_decoded_count)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // queue one decoded byte, counting with saturation
  function automatic void push_decoded(logic [7:0] value, logic last, logic eob);
    decoded_byte_t d;
    if (pred_total < COUNT_SAT) pred_total++;
    d.value     = value;
    d.run_last  = last;
    d.block_end = last && eob;
    d.count     = pred_total[DCOUNT_WIDTH-1:0];
    decoded_q.push_back(d);
  endfunction

  // expected decoded bytes for one accepted compressed byte
  function automatic void predict_decode(logic [7:0] b, logic eob);
    logic [7:0] v;
    int         len;
    case (pred_phase)
      ST_LITERAL: begin
        push_decoded(b, 1'b1, eob);
        pred_left = pred_left - 7'd1;
        if (pred_left == 7'd0) pred_phase = ST_HEADER;
      end
      ST_VALUE: begin
        len = (pred_left > 7'd64) ? 64 : int'(pred_left);
        v = b;
        for (int i = 0; i < len; i++) begin
          push_decoded(v, i == len - 1, eob);
          if (pred_kind == KIND_DOWN) v = v - 8'd1;
          else if (pred_kind == KIND_UP) v = v + 8'd1;
        end
        pred_left  = 7'd0;
        pred_phase = ST_HEADER;
      end
      default: begin
        pred_kind  = 2'(b >> CODE_SHIFT);
        pred_left  = 7'(b & COUNT_MASK) + 7'd1;
        pred_phase = (pred_kind == KIND_LITERAL) ? ST_LITERAL : ST_VALUE;
      end
    endcase
    // block end clears everything, dropping any unfinished token
    if (eob) begin
      pred_phase = ST_HEADER;
      pred_kind  = KIND_LITERAL;
      pred_left  = 7'd0;
      pred_total = 64'd0;
    end
  endfunction

  // offer one compressed byte and wait for its request to be taken
  task automatic send_byte(logic [7:0] b, logic eob);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_compressed_byte <= b;
    in_end_of_block    <= eob;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_decode(b, eob);
    bytes_sent++;
  endtask

  // one well-formed token with random content, sometimes cut by a block end
  task automatic send_token(int max_cnt);
    logic [1:0] code;
    logic [5:0] cnt;
    logic       eob;
    code = 2'($urandom_range(0, 3));
    cnt  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(0, max_cnt));
    // noise: block end on a bare header
    if ($urandom_range(0, 19) == 0) begin
      send_byte({code, cnt}, 1'b1);
      return;
    end
    send_byte({code, cnt}, 1'b0);
    if (code == KIND_LITERAL) begin
      for (int i = 0; i <= int'(cnt); i++) begin
        eob = ($urandom_range(0, 15) == 0);
        send_byte(8'($urandom), eob);
        if (eob) return;
      end
    end else begin
      send_byte(8'($urandom), $urandom_range(0, 5) == 0);
    end
  endtask

  // receiver hold-off, counted here in its own process
  task automatic hold_receiver(int cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  task automatic wait_results_drained();
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // compare one decoded request with the oldest expectation
  function automatic void check_decoded();
    if (decoded_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: byte=%02h last=%0b end=%0b count=%0d",
                 out_byte, out_run_last, out_block_end, out_decoded_count);
      return;
    end
    want = decoded_q.pop_front();
    if (out_byte !== want.value || out_run_last !== want.run_last ||
        out_block_end !== want.block_end || out_decoded_count !== want.count) begin
      errors++;
      if (errors <= 10)
        $display(
          "mismatch: exp %02h last=%0b end=%0b cnt=%0d, got %02h last=%0b end=%0b cnt=%0d",
          want.value, want.run_last, want.block_end, want.count,
          out_byte, out_run_last, out_block_end, out_decoded_count);
    end
  endfunction

  // output side: check taken requests, draw random stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_decoded();
      rx_wait = rx_idle ? $urandom_range(0, 5) : 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= hold_active || (rx_wait != 0);
  end

  // extremes of every token kind, wraparound and each block-end case
  task automatic test_directed();
    // single literal of zero, then three literals
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    // longest repeat run
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    // count-down through zero
    send_byte(8'h85, 1'b0);
    send_byte(8'h02, 1'b0);
    // count-up through 255
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFE, 1'b0);
    // shortest repeat run
    send_byte(8'h40, 1'b0);
    send_byte(8'h00, 1'b0);
    // block end on a run value
    send_byte(8'hC1, 1'b0);
    send_byte(8'h10, 1'b1);
    // block end on the last literal of a token
    send_byte(8'h01, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    // literal token cut short by a block end
    send_byte(8'h05, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    // block end on a header, then a fresh block
    send_byte(8'h83, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b1);
  endtask

  task automatic test_random_tokens(int target);
    while (bytes_sent < target) send_token(7);
  endtask

  // back-to-back requests with no idling on either side
  task automatic test_no_idle(int target);
    tx_idle <= 1'b0;
    rx_idle <= 1'b0;
    while (bytes_sent < target) send_token(15);
    tx_idle <= 1'b1;
    rx_idle <= 1'b1;
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_output_hold(int target);
    fork
      hold_receiver(400);
    join_none
    while (bytes_sent < target) send_token(7);
  endtask

  // sender pauses until every expected byte is out, then resumes
  task automatic test_drain_pause(int target);
    while (bytes_sent < target) begin
      send_token(7);
      if ($urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        wait_results_drained();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_tokens(200);
    test_no_idle(270);
    test_output_hold(340);
    test_drain_pause(410);
    in_valid <= 1'b0;
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0) begin
      errors++;
      $display("%0d expected bytes never arrived", decoded_q.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
